// ===== rtl/core/fmr_pkg.sv =====
`timescale 1ns / 1ps

package fmr_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIND_PATTERN    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIND_LENGTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_PATTERN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLACE_LENGTH  = 2'd3;

    localparam int DEF_MAX_FIND_BYTES    = 8;
    localparam int DEF_MAX_REPLACE_BYTES = 8;
    localparam int QUEUE_DEPTH           = 4;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] find_pattern;
        logic [LEN_W-1:0]      find_length;
        logic [CFG_DATA_W-1:0] replace_pattern;
        logic [LEN_W-1:0]      replace_length;
    } t_cfg;

    function automatic logic [LEN_W-1:0] clamp_len(
        input logic [LEN_W-1:0] value,
        input logic [LEN_W-1:0] lo,
        input logic [LEN_W-1:0] hi
    );
        logic [LEN_W-1:0] res;
        res = value;
        if (value < lo) begin
            res = lo;
        end else if (value > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/fmr_front.sv =====
`timescale 1ns / 1ps

module fmr_front #(
    parameter int MAX_FIND_BYTES    = fmr_pkg::DEF_MAX_FIND_BYTES,
    parameter int MAX_REPLACE_BYTES = fmr_pkg::DEF_MAX_REPLACE_BYTES,
    localparam int CW = $clog2(MAX_FIND_BYTES + 2),
    localparam int SW = (MAX_FIND_BYTES + 1) * fmr_pkg::BYTE_W,
    localparam int JW = 1 + CW + SW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fmr_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    input  logic [fmr_pkg::BYTE_W-1:0]    i_text_byte,
    input  logic                          i_end_of_input,
    output logic                          o_stall,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic [JW-1:0]                 o_job
);

    localparam int FW = $clog2(MAX_FIND_BYTES + 1);
    localparam int WW = MAX_FIND_BYTES * fmr_pkg::BYTE_W;

    typedef struct packed {
        logic          use_repl;
        logic [CW-1:0] cnt;
        logic [SW-1:0] seq;
    } t_job;

    logic [WW-1:0] r_win;
    logic [FW-1:0] r_fill;
    logic          r_replaced;

    logic [WW-1:0] n_win;
    logic [FW-1:0] n_fill;
    logic          n_replaced;

    logic [SW-1:0] s_vec;
    logic [SW-1:0] sp_vec;
    logic [SW-1:0] shifted;
    logic [CW-1:0] m_cnt;
    logic [CW-1:0] mp_cnt;
    logic [CW-1:0] l_cnt;
    logic [CW-1:0] p_cnt;
    logic [CW-1:0] seq_cnt;
    logic [fmr_pkg::LEN_W-1:0] repl_len;
    logic          e0;
    logic          boundary;
    logic          match;
    logic          hit;
    logic          flush;
    logic          accept;
    t_job          job;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;

    always_comb begin
        for (int i = 0; i < MAX_FIND_BYTES; i++) begin
            s_vec[i*8 +: 8] = (FW'(i) < r_fill) ? r_win[i*8 +: 8] : i_text_byte;
        end
        s_vec[MAX_FIND_BYTES*8 +: 8] = i_text_byte;
    end

    always_comb begin
        boundary = (i_text_byte == fmr_pkg::NEWLINE) || i_end_of_input;
        e0       = (r_fill == FW'(MAX_FIND_BYTES));
        m_cnt    = CW'(r_fill) + CW'(1);
        mp_cnt   = m_cnt - CW'(e0);
        l_cnt    = CW'(fmr_pkg::clamp_len(i_cfg.find_length, 4'd1, 4'(MAX_FIND_BYTES)));
        repl_len = fmr_pkg::clamp_len(i_cfg.replace_length, 4'd0, 4'(MAX_REPLACE_BYTES));
        sp_vec   = e0 ? (s_vec >> 8) : s_vec;
        match    = 1'b1;
        for (int i = 0; i < MAX_FIND_BYTES; i++) begin
            if (CW'(i) < l_cnt && sp_vec[i*8 +: 8] != i_cfg.find_pattern[i*8 +: 8]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        hit   = 1'b0;
        flush = 1'b0;
        p_cnt = CW'(e0);
        if (r_replaced) begin
            flush = 1'b1;
        end else begin
            if (mp_cnt > l_cnt) begin
                p_cnt = m_cnt - l_cnt;
            end else if (mp_cnt == l_cnt && match) begin
                hit = 1'b1;
            end else if (mp_cnt == l_cnt) begin
                p_cnt = CW'(e0) + CW'(!boundary);
            end
            flush = boundary && !hit;
        end
        seq_cnt    = flush ? m_cnt : p_cnt;
        n_replaced = (r_replaced || hit) && !boundary;
        shifted    = s_vec >> {p_cnt, 3'b000};
        n_win      = shifted[WW-1:0];
        n_fill     = (flush || hit) ? '0 : FW'(m_cnt - p_cnt);
    end

    always_comb begin
        job.use_repl = hit;
        job.cnt      = seq_cnt;
        job.seq      = s_vec;
        o_job        = job;
        o_push       = accept && (seq_cnt != '0 || (hit && repl_len != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_replaced <= 1'b0;
        end else if (accept) begin
            r_fill     <= n_fill;
            r_replaced <= n_replaced;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== rtl/core/fmr_queue.sv =====
`timescale 1ns / 1ps

module fmr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fmr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_rd_valid,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [NW-1:0]    r_count;

    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == NW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/core/fmr_back.sv =====
`timescale 1ns / 1ps

module fmr_back #(
    parameter int MAX_FIND_BYTES    = fmr_pkg::DEF_MAX_FIND_BYTES,
    parameter int MAX_REPLACE_BYTES = fmr_pkg::DEF_MAX_REPLACE_BYTES,
    localparam int CW = $clog2(MAX_FIND_BYTES + 2),
    localparam int SW = (MAX_FIND_BYTES + 1) * fmr_pkg::BYTE_W,
    localparam int JW = 1 + CW + SW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fmr_pkg::t_cfg              i_cfg,
    input  logic                       i_q_valid,
    input  logic [JW-1:0]              i_q_data,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [fmr_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last_of_run
);

    localparam int IW = $clog2(MAX_FIND_BYTES + MAX_REPLACE_BYTES + 2);

    typedef struct packed {
        logic          use_repl;
        logic [CW-1:0] cnt;
        logic [SW-1:0] seq;
    } t_job;

    t_job          r_job;
    logic          r_act;
    logic [IW-1:0] r_idx;
    logic          r_ov;
    logic [fmr_pkg::BYTE_W-1:0] r_ob;
    logic          r_ol;

    logic [fmr_pkg::LEN_W-1:0] repl_len;
    logic [IW-1:0] total;
    logic [IW-1:0] rk;
    logic [SW-1:0] seq_sh;
    logic [fmr_pkg::CFG_DATA_W-1:0] repl_sh;
    logic [fmr_pkg::BYTE_W-1:0] cur_byte;
    logic          is_last;
    logic          advance;
    logic          pop;

    always_comb begin
        repl_len = fmr_pkg::clamp_len(i_cfg.replace_length, 4'd0, 4'(MAX_REPLACE_BYTES));
        total    = IW'(r_job.cnt) + (r_job.use_repl ? IW'(repl_len) : '0);
        rk       = r_idx - IW'(r_job.cnt);
        seq_sh   = r_job.seq >> {r_idx, 3'b000};
        repl_sh  = i_cfg.replace_pattern >> {rk, 3'b000};
        cur_byte = (r_idx < IW'(r_job.cnt)) ? seq_sh[7:0] : repl_sh[7:0];
        is_last  = (r_idx == total - IW'(1));
        advance  = r_act && (!r_ov || !i_stall);
        pop      = i_q_valid && (!r_act || (advance && is_last));
    end

    assign o_q_pop       = pop;
    assign o_valid       = r_ov;
    assign o_out_byte    = r_ob;
    assign o_last_of_run = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (pop) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (advance && is_last) begin
                r_act <= 1'b0;
            end else if (advance) begin
                r_idx <= r_idx + IW'(1);
            end
            if (advance) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_q_data;
        end
        if (advance) begin
            r_ob <= cur_byte;
            r_ol <= is_last;
        end
    end

endmodule

// ===== rtl/core/first_match_replace_per_line.sv =====
`timescale 1ns / 1ps
// stream find-and-replace, leftmost match of each newline-terminated line
// input channel: i_valid / o_stall carry one text byte per beat, with
//   i_end_of_input set on the final byte of the stream
// output channel: o_valid / i_stall carry one edited byte per beat;
//   o_last_of_run marks the final byte caused by one input beat
// config: i_cfg_we writes register i_cfg_index (find pattern, find length,
//   replace pattern, replace length) from i_cfg_data; write only while idle
// path: the first byte caused by an input beat passes through the job queue,
//   the job register of the output sequencer and then its output byte register
// throughput: the output side sends one byte per cycle while jobs are waiting
//   and i_stall is low; an input beat that causes no bytes pushes no job, and
//   held bytes take no output slot until the window releases them
// a four-entry job queue sits between the window logic and the output
//   sequencer; o_stall rises only when that queue is full
// stall: a stalled output byte holds, jobs back up in the queue, then the
//   input is stalled
// reset: window empty, line not replaced, find length 1, other registers 0

module first_match_replace_per_line #(
    parameter int MAX_FIND_BYTES    = fmr_pkg::DEF_MAX_FIND_BYTES,
    parameter int MAX_REPLACE_BYTES = fmr_pkg::DEF_MAX_REPLACE_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fmr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [fmr_pkg::BYTE_W-1:0]      i_text_byte,
    input  logic                            i_end_of_input,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [fmr_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_last_of_run
);

    localparam int CW = $clog2(MAX_FIND_BYTES + 2);
    localparam int SW = (MAX_FIND_BYTES + 1) * fmr_pkg::BYTE_W;
    localparam int JW = 1 + CW + SW;

    fmr_pkg::t_cfg r_cfg;

    logic          q_full;
    logic          q_push;
    logic [JW-1:0] q_wdata;
    logic          q_pop;
    logic          q_valid;
    logic [JW-1:0] q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.find_pattern    <= '0;
            r_cfg.find_length     <= 4'd1;
            r_cfg.replace_pattern <= '0;
            r_cfg.replace_length  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fmr_pkg::CFG_FIND_PATTERN:    r_cfg.find_pattern <= i_cfg_data;
                fmr_pkg::CFG_FIND_LENGTH:
                    r_cfg.find_length <= i_cfg_data[fmr_pkg::LEN_W-1:0];
                fmr_pkg::CFG_REPLACE_PATTERN: r_cfg.replace_pattern <= i_cfg_data;
                fmr_pkg::CFG_REPLACE_LENGTH:
                    r_cfg.replace_length <= i_cfg_data[fmr_pkg::LEN_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    fmr_front #(
        .MAX_FIND_BYTES    (MAX_FIND_BYTES),
        .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .i_text_byte    (i_text_byte),
        .i_end_of_input (i_end_of_input),
        .o_stall        (o_stall),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_job          (q_wdata)
    );

    fmr_queue #(
        .WIDTH (JW),
        .DEPTH (fmr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_wdata),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_rd_valid  (q_valid),
        .o_rd_data   (q_rdata)
    );

    fmr_back #(
        .MAX_FIND_BYTES    (MAX_FIND_BYTES),
        .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== tb/first_match_replace_per_line_tb.sv =====
`timescale 1ns / 1ps

module first_match_replace_per_line_tb;
    import fmr_pkg::*;

    localparam int MAX_FIND      = DEF_MAX_FIND_BYTES;
    localparam int MAX_REPL      = DEF_MAX_REPLACE_BYTES;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 20;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 10;
    localparam int PHASE_BEATS   = 40;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
    typedef enum int {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } edit_beat_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [BYTE_W-1:0]      b;
        logic                   eoi;
        bit                     typed;
        int                     typed_count;
        logic [BYTE_W-1:0]      typed_first;
    } row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic [BYTE_W-1:0]      i_text_byte;
    logic                   i_end_of_input;
    logic                   o_valid;
    logic                   i_stall;
    logic [BYTE_W-1:0]      o_out_byte;
    logic                   o_last_of_run;

    // predictor copy of the registers and the window
    logic [CFG_DATA_W-1:0] cfg_find_pat;
    logic [LEN_W-1:0]      cfg_find_len;
    logic [CFG_DATA_W-1:0] cfg_repl_pat;
    logic [LEN_W-1:0]      cfg_repl_len;
    logic [BYTE_W-1:0]     held_bytes [MAX_FIND];
    int                    held_count;
    bit                    line_done;

    edit_beat_t edited_q [$];
    edit_beat_t run_q [$];
    row_t       plan_q [$];

    int errors;
    int hold_reqs;
    int burst_left;

    first_match_replace_per_line DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_input(i_end_of_input),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("first_match_replace_per_line_tb NOT OK");
        $finish;
    end

    function automatic int find_len_now();
        int l;
        l = int'(cfg_find_len);
        if (l < 1) l = 1;
        if (l > MAX_FIND) l = MAX_FIND;
        return l;
    endfunction

    function automatic void release_oldest();
        edit_beat_t eb;
        if (held_count == 0) return;
        eb.data = held_bytes[0];
        eb.last = 1'b0;
        run_q.push_back(eb);
        for (int i = 1; i < held_count && i < MAX_FIND; i++) held_bytes[i-1] = held_bytes[i];
        held_count--;
    endfunction

    function automatic bit window_hit(input int l);
        for (int i = 0; i < l && i < MAX_FIND; i++) begin
            if (held_bytes[i] != cfg_find_pat[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // bytes released by one input beat, left in run_q
    function automatic void edit_byte(input logic [BYTE_W-1:0] b, input logic eoi);
        bit         boundary;
        int         l;
        int         r;
        edit_beat_t eb;
        boundary = (b == NEWLINE) || eoi;
        l = find_len_now();
        run_q.delete();
        if (held_count >= MAX_FIND) release_oldest();
        held_bytes[held_count % MAX_FIND] = b;
        held_count++;
        if (!line_done) begin
            if (held_count > l) begin
                while (held_count > l) release_oldest();
            end else if (held_count == l) begin
                if (window_hit(l)) begin
                    r = int'(cfg_repl_len);
                    if (r > MAX_REPL) r = MAX_REPL;
                    for (int i = 0; i < r; i++) begin
                        eb.data = cfg_repl_pat[8*i +: 8];
                        eb.last = 1'b0;
                        run_q.push_back(eb);
                    end
                    held_count = 0;
                    line_done = 1'b1;
                end else if (!boundary) begin
                    release_oldest();
                end
            end
        end
        if (line_done || boundary) begin
            while (held_count > 0) release_oldest();
        end
        if (boundary) line_done = 1'b0;
        if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 8'h61 + 8'($urandom_range(0, 2));
        if (r == 7) return NEWLINE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (edited_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FIND_PATTERN:    cfg_find_pat = data;
            CFG_FIND_LENGTH:     cfg_find_len = data[LEN_W-1:0];
            CFG_REPLACE_PATTERN: cfg_repl_pat = data;
            CFG_REPLACE_LENGTH:  cfg_repl_len = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // sender works in bursts with gaps in between
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic eoi, input bit typed,
                             input int typed_count, input logic [BYTE_W-1:0] typed_first);
        edit_beat_t eb;
        i_valid        <= 1'b1;
        i_text_byte    <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        edit_byte(b, eoi);
        if (typed) begin
            run_q.delete();
            if (typed_count > 0) begin
                eb.data = typed_first;
                eb.last = 1'b1;
                run_q.push_back(eb);
            end
        end
        foreach (run_q[i]) edited_q.push_back(run_q[i]);
    endtask

    task automatic offer(input logic [BYTE_W-1:0] b, input logic eoi);
        pace();
        send_beat(b, eoi, 1'b0, 0, '0);
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        row_t row;
        row = '{ROW_CFG, idx, data, '0, 1'b0, 1'b0, 0, '0};
        plan_q.push_back(row);
    endtask

    task automatic add_beat(input logic [BYTE_W-1:0] b, input logic eoi);
        row_t row;
        row = '{ROW_BEAT, CFG_FIND_PATTERN, '0, b, eoi, 1'b0, 0, '0};
        plan_q.push_back(row);
    endtask

    task automatic add_typed(input logic [BYTE_W-1:0] b, input logic eoi, input int count,
                             input logic [BYTE_W-1:0] first);
        row_t row;
        row = '{ROW_BEAT, CFG_FIND_PATTERN, '0, b, eoi, 1'b1, count, first};
        plan_q.push_back(row);
    endtask

    task automatic set_phase_cfg(input int k);
        logic [CFG_DATA_W-1:0] fp;
        logic [LEN_W-1:0]      fl;
        logic [LEN_W-1:0]      rl;
        for (int i = 0; i < 8; i++) fp[8*i +: 8] = pick_byte();
        case (k)
            0: begin
                fl = 4'd8;
                rl = 4'd8;
            end
            1: begin
                fl = 4'd1;
                rl = 4'd0;
            end
            2: begin
                fl = 4'd0;
                rl = 4'd15;
            end
            3: begin
                fl = 4'd15;
                rl = 4'd9;
            end
            default: begin
                fl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
                rl = 4'($urandom_range(0, 15));
            end
        endcase
        if (k == 5) fp = {$urandom, $urandom};
        write_reg(CFG_FIND_PATTERN, fp);
        write_reg(CFG_FIND_LENGTH, CFG_DATA_W'(fl));
        write_reg(CFG_REPLACE_PATTERN, {$urandom, $urandom});
        write_reg(CFG_REPLACE_LENGTH, CFG_DATA_W'(rl));
    endtask

    // mostly copies and prefixes of the find pattern, plus newlines and noise
    task automatic run_phase(input int n_items);
        int sent;
        int r;
        int l;
        int cut;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            l = find_len_now();
            if (r < 45) begin
                cut = (r < 30) ? l : $urandom_range(1, l);
                for (int i = 0; i < cut; i++) begin
                    offer(cfg_find_pat[8*i +: 8], 1'b0);
                    sent++;
                end
            end else begin
                if (r < 65) offer(8'h61 + 8'($urandom_range(0, 2)), 1'b0);
                else if (r < 80) offer(NEWLINE, 1'b0);
                else if (r < 95) offer(8'($urandom_range(0, 255)), 1'b0);
                else offer(pick_byte(), 1'b1);
                sent++;
            end
        end
    endtask

    // receiver stall pattern, with long holds on request
    initial begin
        stall_mode_t mode;
        int          span;
        int          holds_seen;
        int          hold_left;
        mode = STALL_NONE;
        span = 0;
        holds_seen = 0;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_seen != hold_reqs) begin
                holds_seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (span == 0) begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(16, 96);
                end
                span--;
                case (mode)
                    STALL_NONE:   i_stall <= 1'b0;
                    STALL_LIGHT:  i_stall <= ($urandom_range(0, 4) == 0);
                    STALL_HEAVY:  i_stall <= ($urandom_range(0, 9) < 6);
                    STALL_TOGGLE: i_stall <= ~i_stall;
                    default:      i_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        edit_beat_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (edited_q.size() == 0) begin
                $error("out_byte: expected none, got %02h", o_out_byte);
                errors++;
            end else begin
                want = edited_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_FIND_PATTERN;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_text_byte    = '0;
        i_end_of_input = 1'b0;
        errors         = 0;
        hold_reqs      = 0;
        burst_left     = 0;
        cfg_find_pat   = '0;
        cfg_find_len   = 4'd1;
        cfg_repl_pat   = '0;
        cfg_repl_len   = 4'd0;
        held_count     = 0;
        line_done      = 1'b0;
        foreach (held_bytes[i]) held_bytes[i] = '0;

        // after reset: find one zero byte, delete it
        add_typed(8'h41, 1'b0, 1, 8'h41);
        add_typed(8'h00, 1'b0, 0, 8'h00);
        add_typed(8'h00, 1'b0, 1, 8'h00);
        add_typed(8'hFF, 1'b1, 1, 8'hFF);
        add_typed(8'h00, 1'b0, 0, 8'h00);
        add_typed(NEWLINE, 1'b0, 1, NEWLINE);
        // match that takes the newline, replace length saturates
        add_cfg(CFG_FIND_PATTERN, 64'h0000_0000_000A_6261);
        add_cfg(CFG_FIND_LENGTH, 64'd3);
        add_cfg(CFG_REPLACE_PATTERN, 64'h4847_4645_4443_4241);
        add_cfg(CFG_REPLACE_LENGTH, 64'd15);
        add_beat(8'h61, 1'b0);
        add_beat(8'h62, 1'b0);
        add_beat(NEWLINE, 1'b0);
        // line shorter than the pattern
        add_beat(8'h61, 1'b0);
        add_beat(NEWLINE, 1'b0);
        // newline together with end of input
        add_beat(8'h61, 1'b0);
        add_beat(8'h62, 1'b0);
        add_beat(NEWLINE, 1'b1);
        add_beat(8'h78, 1'b1);
        // find length zero acts as one
        add_cfg(CFG_FIND_LENGTH, 64'd0);
        add_cfg(CFG_REPLACE_LENGTH, 64'd0);
        add_typed(8'h61, 1'b0, 0, 8'h00);
        add_typed(8'h61, 1'b0, 1, 8'h61);
        add_typed(NEWLINE, 1'b0, 1, NEWLINE);
        // find length saturates, then shrinks while the window holds bytes
        add_cfg(CFG_FIND_PATTERN, '1);
        add_cfg(CFG_FIND_LENGTH, 64'd15);
        add_cfg(CFG_REPLACE_PATTERN, '0);
        add_cfg(CFG_REPLACE_LENGTH, 64'd1);
        repeat (5) add_beat(8'hFF, 1'b0);
        add_cfg(CFG_FIND_LENGTH, 64'd2);
        add_beat(8'hFF, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(NEWLINE, 1'b0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_q[i]) begin
            if (plan_q[i].kind == ROW_CFG) begin
                write_reg(plan_q[i].idx, plan_q[i].data);
            end else begin
                pace();
                send_beat(plan_q[i].b, plan_q[i].eoi, plan_q[i].typed,
                          plan_q[i].typed_count, plan_q[i].typed_first);
            end
        end

        for (int k = 0; k < PHASES; k++) begin
            set_phase_cfg(k);
            if (k == 3 || k == 7) hold_reqs++;
            run_phase(PHASE_BEATS);
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (edited_q.size() != 0) begin
            $error("out_byte: %0d expected beats never arrived", edited_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("first_match_replace_per_line_tb OK");
        end else begin
            $display("first_match_replace_per_line_tb NOT OK");
        end
        $finish;
    end

endmodule
